@@ sv/qxpm_pkg.sv @@
// package: shared constants, payload type and pulse clamp for the quad x pid mixer
`timescale 1ns / 1ps

package qxpm_pkg;

    localparam int GAIN_W  = 48;
    localparam int ANGLE_W = 16;
    localparam int ERR_W   = 17;
    localparam int ISUM_W  = 32;
    localparam int DELTA_W = 18;
    localparam int THR_W   = 11;
    localparam int PULSE_W = 11;
    localparam int FRAC_W  = 16;
    localparam int AXIS_W  = 50;
    localparam int MIX_W   = 52;
    localparam int REQ_W   = 2;
    localparam int CFG_IDX_W = 2;

    localparam logic [REQ_W-1:0] REQ_TICK   = 2'd0;
    localparam logic [REQ_W-1:0] REQ_ARM    = 2'd1;
    localparam logic [REQ_W-1:0] REQ_DISARM = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_YAW_GAINS   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PITCH_GAINS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ROLL_GAINS  = 2'd2;

    localparam logic [GAIN_W-1:0] YAW_GAINS_RST   = 48'h0000_0029_2800;
    localparam logic [GAIN_W-1:0] PITCH_GAINS_RST = 48'h5000_0052_1266;
    localparam logic [GAIN_W-1:0] ROLL_GAINS_RST  = 48'h5000_0052_1266;

    localparam logic [THR_W-1:0]   THROTTLE_ON  = 11'd1012;
    localparam logic [PULSE_W-1:0] PULSE_MIN_US = 11'd1100;
    localparam logic [PULSE_W-1:0] PULSE_MAX_US = 11'd1600;

    localparam longint PULSE_LO_FX = longint'(PULSE_MIN_US) << FRAC_W;
    localparam longint PULSE_HI_FX = (longint'(PULSE_MAX_US) + 64'sd1) << FRAC_W;

    typedef struct packed {
        logic [REQ_W-1:0]          req_type;
        logic signed [ANGLE_W-1:0] yaw_setpoint;
        logic signed [ANGLE_W-1:0] pitch_setpoint;
        logic signed [ANGLE_W-1:0] roll_setpoint;
        logic signed [ANGLE_W-1:0] yaw_angle;
        logic signed [ANGLE_W-1:0] pitch_angle;
        logic signed [ANGLE_W-1:0] roll_angle;
        logic [THR_W-1:0]          throttle_us;
    } tick_beat_t;

    // floor to whole microseconds and clamp to the pulse window
    function automatic logic [PULSE_W-1:0] clamp_pulse(input logic signed [MIX_W-1:0] v);
        logic [PULSE_W-1:0] res;
        if (v < MIX_W'(PULSE_LO_FX))
        begin
            res = PULSE_MIN_US;
        end
        else if (v >= MIX_W'(PULSE_HI_FX))
        begin
            res = PULSE_MAX_US;
        end
        else
        begin
            res = v[FRAC_W+PULSE_W-1:FRAC_W];
        end
        return res;
    endfunction

endpackage

@@ sv/qxpm_tick_if.sv @@
// interface: tick request channel carrying setpoints, angles and throttle
`timescale 1ns / 1ps

interface qxpm_tick_if;
    logic                                     valid;
    logic                                     ready;
    logic [qxpm_pkg::REQ_W-1:0]               req_type;
    logic signed [qxpm_pkg::ANGLE_W-1:0]      yaw_setpoint;
    logic signed [qxpm_pkg::ANGLE_W-1:0]      pitch_setpoint;
    logic signed [qxpm_pkg::ANGLE_W-1:0]      roll_setpoint;
    logic signed [qxpm_pkg::ANGLE_W-1:0]      yaw_angle;
    logic signed [qxpm_pkg::ANGLE_W-1:0]      pitch_angle;
    logic signed [qxpm_pkg::ANGLE_W-1:0]      roll_angle;
    logic [qxpm_pkg::THR_W-1:0]               throttle_us;

    modport source (
        output valid, req_type, yaw_setpoint, pitch_setpoint, roll_setpoint,
               yaw_angle, pitch_angle, roll_angle, throttle_us,
        input  ready
    );
    modport sink (
        input  valid, req_type, yaw_setpoint, pitch_setpoint, roll_setpoint,
               yaw_angle, pitch_angle, roll_angle, throttle_us,
        output ready
    );
endinterface

@@ sv/qxpm_pulse_if.sv @@
// interface: motor pulse result channel
`timescale 1ns / 1ps

interface qxpm_pulse_if;
    logic                           valid;
    logic                           ready;
    logic [qxpm_pkg::PULSE_W-1:0]   motor_a_us;
    logic [qxpm_pkg::PULSE_W-1:0]   motor_b_us;
    logic [qxpm_pkg::PULSE_W-1:0]   motor_c_us;
    logic [qxpm_pkg::PULSE_W-1:0]   motor_d_us;
    logic                           motors_run;

    modport source (
        output valid, motor_a_us, motor_b_us, motor_c_us, motor_d_us, motors_run,
        input  ready
    );
    modport sink (
        input  valid, motor_a_us, motor_b_us, motor_c_us, motor_d_us, motors_run,
        output ready
    );
endinterface

@@ sv/qxpm_cfg_if.sv @@
// interface: gain register write channel
`timescale 1ns / 1ps

interface qxpm_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [qxpm_pkg::CFG_IDX_W-1:0]   index;
    logic [qxpm_pkg::GAIN_W-1:0]      data;

    modport source (
        output valid, index, data,
        input  ready
    );
    modport sink (
        input  valid, index, data,
        output ready
    );
endinterface

@@ sv/quad_x_pid_mixer.sv @@
// top level: three-axis pid attitude controller with x-frame motor mixer
//
//   channel  role    beat contents
//   tick     sink    req_type, yaw/pitch/roll setpoint and angle, throttle_us
//   pulse    source  motor_a_us .. motor_d_us, motors_run
//   cfg      sink    index 0 yaw, 1 pitch, 2 roll gains; data packed unsigned q0.16 kp/ki/kd
//
// one beat per cycle sustained while pulse is ready; from tick accept to pulse valid a beat passes
// the input register, then pid and mix logic into the result register
// pid state updates when a beat leaves the input register, so the next beat sees it
// rst_n clears state, arming, gains to their defaults and both valid flags
// pulse stall backs up through ready; cfg is always ready
`timescale 1ns / 1ps

module quad_x_pid_mixer (
    input  logic                clk,
    input  logic                rst_n,
    qxpm_tick_if.sink           tick,
    qxpm_pulse_if.source        pulse,
    qxpm_cfg_if.sink            cfg
);

    localparam int NUM_AXES = 3;

    // input stage
    logic                       s0_valid_reg;
    qxpm_pkg::tick_beat_t       s0_reg;
    logic                       s0_advance;

    // result stage
    logic                             out_valid_reg;
    logic [qxpm_pkg::PULSE_W-1:0]     motor_a_reg, motor_b_reg, motor_c_reg, motor_d_reg;
    logic                             run_reg;
    logic [qxpm_pkg::PULSE_W-1:0]     motor_a_next, motor_b_next, motor_c_next, motor_d_next;
    logic                             run_next;

    // controller state
    logic [qxpm_pkg::GAIN_W-1:0]        gains_reg    [NUM_AXES];
    logic signed [qxpm_pkg::ISUM_W-1:0] integral_reg [NUM_AXES];
    logic signed [qxpm_pkg::ERR_W-1:0]  last_err_reg [NUM_AXES];
    logic                               armed_reg;
    logic signed [qxpm_pkg::ISUM_W-1:0] integral_next [NUM_AXES];
    logic signed [qxpm_pkg::ERR_W-1:0]  last_err_next [NUM_AXES];
    logic                               armed_next;

    // datapath
    logic signed [qxpm_pkg::ANGLE_W-1:0] sp  [NUM_AXES];
    logic signed [qxpm_pkg::ANGLE_W-1:0] ang [NUM_AXES];
    logic signed [qxpm_pkg::ERR_W-1:0]   err [NUM_AXES];
    logic signed [qxpm_pkg::ISUM_W:0]    sum_wide [NUM_AXES];
    logic signed [qxpm_pkg::ISUM_W-1:0]  sum_sat  [NUM_AXES];
    logic signed [qxpm_pkg::DELTA_W-1:0] delta    [NUM_AXES];
    logic signed [16:0]                  kp_s [NUM_AXES];
    logic signed [16:0]                  ki_s [NUM_AXES];
    logic signed [16:0]                  kd_s [NUM_AXES];
    logic signed [33:0]                  p_prod [NUM_AXES];
    logic signed [48:0]                  i_prod [NUM_AXES];
    logic signed [34:0]                  d_prod [NUM_AXES];
    logic signed [qxpm_pkg::AXIS_W-1:0]  axis_out [NUM_AXES];
    logic signed [qxpm_pkg::MIX_W-1:0]   base, yaw_v, pitch_v, roll_v;
    logic signed [qxpm_pkg::MIX_W-1:0]   mix_a, mix_b, mix_c, mix_d;
    logic                                pid_run;

    assign s0_advance = s0_valid_reg && (!out_valid_reg || pulse.ready);
    assign tick.ready = !s0_valid_reg || s0_advance;
    assign cfg.ready  = 1'b1;

    assign sp[0]  = s0_reg.yaw_setpoint;
    assign sp[1]  = s0_reg.pitch_setpoint;
    assign sp[2]  = s0_reg.roll_setpoint;
    assign ang[0] = s0_reg.yaw_angle;
    assign ang[1] = s0_reg.pitch_angle;
    assign ang[2] = s0_reg.roll_angle;

    always_comb
    begin
        for (int a = 0; a < NUM_AXES; a++)
        begin
            kp_s[a]     = $signed({1'b0, gains_reg[a][15:0]});
            ki_s[a]     = $signed({1'b0, gains_reg[a][31:16]});
            kd_s[a]     = $signed({1'b0, gains_reg[a][47:32]});
            err[a]      = qxpm_pkg::ERR_W'(sp[a]) - qxpm_pkg::ERR_W'(ang[a]);
            sum_wide[a] = (qxpm_pkg::ISUM_W+1)'(integral_reg[a])
                        + (qxpm_pkg::ISUM_W+1)'(err[a]);
            // saturate the running sum to 32 bits
            if (sum_wide[a][qxpm_pkg::ISUM_W] != sum_wide[a][qxpm_pkg::ISUM_W-1])
            begin
                sum_sat[a] = sum_wide[a][qxpm_pkg::ISUM_W] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
            end
            else
            begin
                sum_sat[a] = $signed(sum_wide[a][qxpm_pkg::ISUM_W-1:0]);
            end
            delta[a]    = qxpm_pkg::DELTA_W'(err[a]) - qxpm_pkg::DELTA_W'(last_err_reg[a]);
            p_prod[a]   = err[a] * kp_s[a];
            i_prod[a]   = sum_sat[a] * ki_s[a];
            d_prod[a]   = delta[a] * kd_s[a];
            axis_out[a] = qxpm_pkg::AXIS_W'(p_prod[a]) + qxpm_pkg::AXIS_W'(i_prod[a])
                        + qxpm_pkg::AXIS_W'(d_prod[a]);
        end
    end

    always_comb
    begin
        base    = $signed({{(qxpm_pkg::MIX_W-qxpm_pkg::THR_W-qxpm_pkg::FRAC_W){1'b0}},
                           s0_reg.throttle_us, {qxpm_pkg::FRAC_W{1'b0}}});
        yaw_v   = qxpm_pkg::MIX_W'(axis_out[0]);
        pitch_v = qxpm_pkg::MIX_W'(axis_out[1]);
        roll_v  = qxpm_pkg::MIX_W'(axis_out[2]);
        mix_a   = base + roll_v + pitch_v - yaw_v;
        mix_b   = base - roll_v + pitch_v + yaw_v;
        mix_c   = base + roll_v - pitch_v + yaw_v;
        mix_d   = base - roll_v - pitch_v - yaw_v;
    end

    always_comb
    begin
        pid_run      = 1'b0;
        armed_next   = armed_reg;
        run_next     = 1'b0;
        motor_a_next = '0;
        motor_b_next = '0;
        motor_c_next = '0;
        motor_d_next = '0;
        for (int a = 0; a < NUM_AXES; a++)
        begin
            integral_next[a] = integral_reg[a];
            last_err_next[a] = last_err_reg[a];
        end
        case (s0_reg.req_type)
            qxpm_pkg::REQ_ARM,
            qxpm_pkg::REQ_DISARM:
            begin
                armed_next = (s0_reg.req_type == qxpm_pkg::REQ_ARM);
                for (int a = 0; a < NUM_AXES; a++)
                begin
                    integral_next[a] = '0;
                    last_err_next[a] = '0;
                end
            end
            qxpm_pkg::REQ_TICK:
            begin
                if (armed_reg)
                begin
                    run_next = 1'b1;
                    if (s0_reg.throttle_us < qxpm_pkg::THROTTLE_ON)
                    begin
                        motor_a_next = qxpm_pkg::clamp_pulse(base);
                        motor_b_next = qxpm_pkg::clamp_pulse(base);
                        motor_c_next = qxpm_pkg::clamp_pulse(base);
                        motor_d_next = qxpm_pkg::clamp_pulse(base);
                    end
                    else
                    begin
                        pid_run      = 1'b1;
                        motor_a_next = qxpm_pkg::clamp_pulse(mix_a);
                        motor_b_next = qxpm_pkg::clamp_pulse(mix_b);
                        motor_c_next = qxpm_pkg::clamp_pulse(mix_c);
                        motor_d_next = qxpm_pkg::clamp_pulse(mix_d);
                    end
                end
            end
            default:
            begin
                run_next = 1'b0;
            end
        endcase
        if (pid_run)
        begin
            for (int a = 0; a < NUM_AXES; a++)
            begin
                integral_next[a] = sum_sat[a];
                last_err_next[a] = err[a];
            end
        end
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg <= 1'b0;
        end
        else if (tick.ready)
        begin
            s0_valid_reg <= tick.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (tick.valid && tick.ready)
        begin
            s0_reg.req_type       <= tick.req_type;
            s0_reg.yaw_setpoint   <= tick.yaw_setpoint;
            s0_reg.pitch_setpoint <= tick.pitch_setpoint;
            s0_reg.roll_setpoint  <= tick.roll_setpoint;
            s0_reg.yaw_angle      <= tick.yaw_angle;
            s0_reg.pitch_angle    <= tick.pitch_angle;
            s0_reg.roll_angle     <= tick.roll_angle;
            s0_reg.throttle_us    <= tick.throttle_us;
        end
    end

    // controller state and gains
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            armed_reg    <= 1'b0;
            gains_reg[0] <= qxpm_pkg::YAW_GAINS_RST;
            gains_reg[1] <= qxpm_pkg::PITCH_GAINS_RST;
            gains_reg[2] <= qxpm_pkg::ROLL_GAINS_RST;
            for (int a = 0; a < NUM_AXES; a++)
            begin
                integral_reg[a] <= '0;
                last_err_reg[a] <= '0;
            end
        end
        else
        begin
            if (s0_advance)
            begin
                armed_reg <= armed_next;
                for (int a = 0; a < NUM_AXES; a++)
                begin
                    integral_reg[a] <= integral_next[a];
                    last_err_reg[a] <= last_err_next[a];
                end
            end
            if (cfg.valid)
            begin
                case (cfg.index)
                    qxpm_pkg::CFG_YAW_GAINS:   gains_reg[0] <= cfg.data;
                    qxpm_pkg::CFG_PITCH_GAINS: gains_reg[1] <= cfg.data;
                    qxpm_pkg::CFG_ROLL_GAINS:  gains_reg[2] <= cfg.data;
                    default:                   gains_reg[0] <= gains_reg[0];
                endcase
            end
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s0_advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (pulse.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s0_advance)
        begin
            motor_a_reg <= motor_a_next;
            motor_b_reg <= motor_b_next;
            motor_c_reg <= motor_c_next;
            motor_d_reg <= motor_d_next;
            run_reg     <= run_next;
        end
    end

    assign pulse.valid      = out_valid_reg;
    assign pulse.motor_a_us = motor_a_reg;
    assign pulse.motor_b_us = motor_b_reg;
    assign pulse.motor_c_us = motor_c_reg;
    assign pulse.motor_d_us = motor_d_reg;
    assign pulse.motors_run = run_reg;

    // driven motors a and d stay inside the pulse window
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && run_reg) |->
            (motor_a_reg >= qxpm_pkg::PULSE_MIN_US) && (motor_a_reg <= qxpm_pkg::PULSE_MAX_US)
         && (motor_d_reg >= qxpm_pkg::PULSE_MIN_US) && (motor_d_reg <= qxpm_pkg::PULSE_MAX_US))
        else $error("driven motor pulse outside window");

    // stop-all beats carry zero pulses
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !run_reg) |->
            (motor_a_reg == '0) && (motor_b_reg == '0)
         && (motor_c_reg == '0) && (motor_d_reg == '0))
        else $error("stop-all beat with nonzero pulse");

    // arm or disarm clears the pid state
    assert property (@(posedge clk) disable iff (!rst_n)
        (s0_advance && ((s0_reg.req_type == qxpm_pkg::REQ_ARM)
                     || (s0_reg.req_type == qxpm_pkg::REQ_DISARM))) |=>
            (integral_reg[0] == '0) && (integral_reg[1] == '0) && (integral_reg[2] == '0)
         && (last_err_reg[0] == '0) && (last_err_reg[1] == '0) && (last_err_reg[2] == '0))
        else $error("pid state not cleared on arm request");

    // arm request leaves the controller armed
    assert property (@(posedge clk) disable iff (!rst_n)
        (s0_advance && (s0_reg.req_type == qxpm_pkg::REQ_ARM)) |=> armed_reg)
        else $error("arm request did not arm");

    // a beat taken while disarmed never drives the motors
    assert property (@(posedge clk) disable iff (!rst_n)
        (s0_advance && !armed_reg) |=> (out_valid_reg && !run_reg))
        else $error("disarmed beat drove motors");

endmodule
